>>> hdl/tdma_sched_pkg.sv
// Shared types and constants for the TDMA own-slot transmit scheduler.
// Holds the request/response payload structs, opcodes and register indexes.
// No dependencies.
package tdma_sched_pkg;

   // Queue sizing
   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   // Field widths
   localparam int HANDLE_W = 16;
   localparam int PERIOD_W = 16;
   localparam int SLOT_W   = 24;
   localparam int TIME_W   = 25;
   localparam int LEVEL_W  = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // Opcodes
   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_ENQUEUE = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_SLOT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_US     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GUARD_US    = 2'd3;

   // Register reset values
   localparam logic [PERIOD_W-1:0] SLOT_PERIOD_RESET = 16'd10;
   localparam logic [PERIOD_W-1:0] OWN_SLOT_RESET    = 16'd0;
   localparam logic [SLOT_W-1:0]   SLOT_US_RESET     = 24'd800000;
   localparam logic [SLOT_W-1:0]   GUARD_US_RESET    = 24'd1000;

   typedef struct packed {
      logic                opcode;
      logic [HANDLE_W-1:0] packet_handle;
   } req_type;

   typedef struct packed {
      logic                tx_valid;
      logic [HANDLE_W-1:0] tx_handle;
      logic [LEVEL_W-1:0]  queue_level;
      logic                dropped;
      logic                busy_res;
      logic                bad_config;
   } rsp_type;

endpackage

>>> hdl/tdma_own_slot_tx_scheduler.sv
// TDMA own-slot transmit scheduler, top level.
// Depends on tdma_sched_pkg for payload structs, opcodes and register indexes.
//
// Usage:
//   req channel (req_valid/req_stall/req_data) carries one item per transfer:
//   a one-microsecond tick or an enqueue of a packet handle. Every item gives
//   exactly one result on the rsp channel (rsp_valid/rsp_stall/rsp_data):
//   tx flag and handle, queue level, drop flag, busy and bad-config status.
//   csr_wr_en/csr_index/csr_wdata write slot_period, own_slot, slot_us and
//   guard_us; write them only while no results are outstanding.
// Throughput:
//   Unless a stall holds the response register, an item's result is loaded into
//   it at the accepting edge and can transfer in the next cycle; one item per
//   cycle sustained while rsp_stall stays low. Slot counters, FIFO update and
//   result all resolve in the single logic stage between the state registers and the response register.
// Reset: synchronous; restores the register defaults, empties the FIFO,
//   drops any held packet and starts slot 0 at time 0.
// Stall:
//   A stalled result holds in the response register while a skid register
//   takes one more result; req_stall rises while the skid register is full.
module tdma_own_slot_tx_scheduler
   import tdma_sched_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [PTR_BITS-1:0]   PTR_LAST   = PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_FULL = COUNT_BITS'(QUEUE_DEPTH);

   // Configuration registers
   logic [PERIOD_W-1:0] slot_period_ff;
   logic [PERIOD_W-1:0] own_slot_ff;
   logic [SLOT_W-1:0]   slot_us_ff;
   logic [SLOT_W-1:0]   guard_us_ff;

   // Scheduler state
   logic [TIME_W-1:0]     time_in_slot_ff, time_in_slot_in;
   logic [PERIOD_W-1:0]   slot_phase_ff, slot_phase_in;
   logic                  holding_ff, holding_in;
   logic [HANDLE_W-1:0]   held_handle_ff, held_handle_in;
   logic [HANDLE_W-1:0]   fifo_store_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   fifo_head_ff, fifo_head_in;
   logic [PTR_BITS-1:0]   fifo_tail_ff, fifo_tail_in;
   logic [COUNT_BITS-1:0] fifo_count_ff, fifo_count_in;
   logic                  push;

   // Output register and skid register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    skid_valid_ff;
   rsp_type skid_data_ff;

   logic    accept;
   logic    rsp_take;
   rsp_type result;

   // Timing terms
   logic [TIME_W:0]     time_plus;
   logic [TIME_W:0]     slot_len;
   logic                boundary;
   logic [PERIOD_W:0]   phase_plus;
   logic                phase_wrap;
   logic                phase_match;
   logic                bad_config;
   logic                fifo_full;
   logic                fifo_empty;
   logic [HANDLE_W-1:0] head_handle;

   assign accept    = req_valid & ~skid_valid_ff;
   assign rsp_take  = rsp_valid_ff & ~rsp_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Slot boundary and phase terms, computed in parallel
   always_comb begin
      time_plus = {1'b0, time_in_slot_ff} + {{TIME_W{1'b0}}, 1'b1};
      slot_len  = {2'b00, slot_us_ff} + {2'b00, guard_us_ff};
      if (slot_len == '0) begin
         slot_len = {{TIME_W{1'b0}}, 1'b1};
      end
      boundary    = (time_plus >= slot_len);
      phase_plus  = {1'b0, slot_phase_ff} + {{PERIOD_W{1'b0}}, 1'b1};
      phase_wrap  = (phase_plus >= {1'b0, slot_period_ff});
      phase_match = phase_wrap ? (own_slot_ff == '0)
                               : (phase_plus[PERIOD_W-1:0] == own_slot_ff);
      bad_config  = (own_slot_ff >= slot_period_ff);
      fifo_full   = (fifo_count_ff >= COUNT_FULL);
      fifo_empty  = (fifo_count_ff == '0);
      head_handle = fifo_store_ff[fifo_head_ff];
   end

   // Next state and result for the incoming item
   always_comb begin
      time_in_slot_in = time_in_slot_ff;
      slot_phase_in   = slot_phase_ff;
      holding_in      = holding_ff;
      held_handle_in  = held_handle_ff;
      fifo_head_in    = fifo_head_ff;
      fifo_tail_in    = fifo_tail_ff;
      fifo_count_in   = fifo_count_ff;
      push            = 1'b0;
      result          = '0;
      result.bad_config = bad_config;

      if (req_data.opcode == OP_ENQUEUE) begin
         // push unless full, then take the head if idle
         if (fifo_full) begin
            result.dropped = 1'b1;
            result.queue_level = LEVEL_W'(fifo_count_ff);
            if (!holding_ff) begin
               holding_in     = 1'b1;
               held_handle_in = head_handle;
               fifo_head_in   = (fifo_head_ff == PTR_LAST) ? '0 : fifo_head_ff + 1'b1;
               fifo_count_in  = fifo_count_ff - 1'b1;
            end
         end else begin
            push = 1'b1;
            fifo_tail_in = (fifo_tail_ff == PTR_LAST) ? '0 : fifo_tail_ff + 1'b1;
            result.queue_level = LEVEL_W'(fifo_count_ff + 1'b1);
            if (!holding_ff) begin
               // empty queue: the pushed handle goes straight to hold
               holding_in     = 1'b1;
               held_handle_in = fifo_empty ? req_data.packet_handle : head_handle;
               fifo_head_in   = (fifo_head_ff == PTR_LAST) ? '0 : fifo_head_ff + 1'b1;
            end else begin
               fifo_count_in = fifo_count_ff + 1'b1;
            end
         end
      end else begin
         // advance time; at a boundary advance the slot and send if ours
         if (boundary) begin
            time_in_slot_in = '0;
            slot_phase_in   = phase_wrap ? '0 : phase_plus[PERIOD_W-1:0];
            if (holding_ff && !bad_config && phase_match) begin
               result.tx_valid  = 1'b1;
               result.tx_handle = held_handle_ff;
               if (fifo_empty) begin
                  holding_in = 1'b0;
               end else begin
                  held_handle_in = head_handle;
                  fifo_head_in   = (fifo_head_ff == PTR_LAST) ? '0 : fifo_head_ff + 1'b1;
                  fifo_count_in  = fifo_count_ff - 1'b1;
               end
            end
         end else begin
            time_in_slot_in = time_plus[TIME_W-1:0];
         end
         result.queue_level = LEVEL_W'(fifo_count_in);
      end
      result.busy_res = holding_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_period_ff <= SLOT_PERIOD_RESET;
         own_slot_ff    <= OWN_SLOT_RESET;
         slot_us_ff     <= SLOT_US_RESET;
         guard_us_ff    <= GUARD_US_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SLOT_PERIOD: slot_period_ff <= csr_wdata[PERIOD_W-1:0];
            CSR_OWN_SLOT:    own_slot_ff    <= csr_wdata[PERIOD_W-1:0];
            CSR_SLOT_US:     slot_us_ff     <= csr_wdata[SLOT_W-1:0];
            CSR_GUARD_US:    guard_us_ff    <= csr_wdata[SLOT_W-1:0];
            default: ;
         endcase
      end
   end

   // Scheduler control state
   always_ff @(posedge clock) begin
      if (reset) begin
         time_in_slot_ff <= '0;
         slot_phase_ff   <= '0;
         holding_ff      <= 1'b0;
         fifo_head_ff    <= '0;
         fifo_tail_ff    <= '0;
         fifo_count_ff   <= '0;
      end else if (accept) begin
         time_in_slot_ff <= time_in_slot_in;
         slot_phase_ff   <= slot_phase_in;
         holding_ff      <= holding_in;
         fifo_head_ff    <= fifo_head_in;
         fifo_tail_ff    <= fifo_tail_in;
         fifo_count_ff   <= fifo_count_in;
      end
   end

   // Held handle and FIFO storage
   always_ff @(posedge clock) begin
      if (accept) begin
         held_handle_ff <= held_handle_in;
         if (push) begin
            fifo_store_ff[fifo_tail_ff] <= req_data.packet_handle;
         end
      end
   end

   // Output register with skid: drain skid first, hold on stall
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= accept;
         end else begin
            rsp_valid_ff  <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            rsp_data_ff <= skid_data_ff;
            if (accept) begin
               skid_data_ff <= result;
            end
         end else if (accept) begin
            rsp_data_ff <= result;
         end
      end else if (accept) begin
         skid_data_ff <= result;
      end
   end

`ifndef SYNTHESIS
   // skid register only fills behind a held response
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full with empty response register");

   // queue occupancy never exceeds its depth
   assert property (@(posedge clock) disable iff (reset)
      fifo_count_ff <= COUNT_FULL)
      else $error("FIFO count beyond depth");

   // nothing is sent under a bad own slot
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.tx_valid) |-> !rsp_data_ff.bad_config)
      else $error("transmit reported with bad configuration");

   // a drop is reported only with a full queue
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.dropped)
         |-> (rsp_data_ff.queue_level == LEVEL_W'(COUNT_FULL)))
      else $error("drop reported with queue not full");
`endif

endmodule

>>> verif/tdma_sched_checker.sv
// Scoreboard for the TDMA own-slot transmit scheduler: watches the request,
// response and register-write ports, predicts every response and compares.
// Depends on tdma_sched_pkg for payload structs, opcodes and register indexes.
`timescale 1ns / 100ps

module tdma_sched_checker
   import tdma_sched_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending
);

   // Shadow registers
   logic [PERIOD_W-1:0] period_cfg;
   logic [PERIOD_W-1:0] own_cfg;
   logic [SLOT_W-1:0]   slot_cfg;
   logic [SLOT_W-1:0]   guard_cfg;

   // Shadow schedule state
   logic [TIME_W-1:0]   us_in_slot;
   logic [PERIOD_W-1:0] phase;
   bit                  holding;
   logic [HANDLE_W-1:0] held;
   logic [HANDLE_W-1:0] fifo [QUEUE_DEPTH];
   int                  head;
   int                  tail;
   int                  count;

   rsp_type status_due [$];
   rsp_type predicted;
   rsp_type want;
   int      errors = 0;
   int      results_seen = 0;

   // Load the next queued handle into the hold slot, or go idle
   function automatic void take_head();
      if (count == 0) begin
         holding = 1'b0;
      end else begin
         held    = fifo[head];
         head    = (head + 1) % QUEUE_DEPTH;
         count   = count - 1;
         holding = 1'b1;
      end
   endfunction

   // Advance the shadow schedule by one request and return its status
   function automatic rsp_type schedule_step(req_type item);
      rsp_type     r;
      int unsigned span;
      r = '0;
      if (item.opcode == OP_ENQUEUE) begin
         if (count >= QUEUE_DEPTH) begin
            r.dropped = 1'b1;
         end else begin
            fifo[tail] = item.packet_handle;
            tail       = (tail + 1) % QUEUE_DEPTH;
            count      = count + 1;
         end
         r.queue_level = LEVEL_W'(count);
         if (!holding) take_head();
      end else begin
         span = 32'(slot_cfg) + 32'(guard_cfg);
         // a zero-length slot still lasts one tick
         if (span == 0) span = 1;
         if (32'(us_in_slot) + 1 >= span) begin
            us_in_slot = '0;
            phase = (32'(phase) + 1 >= 32'(period_cfg)) ? '0 : phase + 1'b1;
            if (holding && own_cfg < period_cfg && phase == own_cfg) begin
               r.tx_valid  = 1'b1;
               r.tx_handle = held;
               take_head();
            end
         end else begin
            us_in_slot = us_in_slot + 1'b1;
         end
         r.queue_level = LEVEL_W'(count);
      end
      r.busy_res   = holding;
      r.bad_config = (own_cfg >= period_cfg);
      return r;
   endfunction

   // Track writes, predict on each request transfer, compare each response transfer
   always @(posedge clock) begin
      if (reset) begin
         period_cfg = SLOT_PERIOD_RESET;
         own_cfg    = OWN_SLOT_RESET;
         slot_cfg   = SLOT_US_RESET;
         guard_cfg  = GUARD_US_RESET;
         us_in_slot = '0;
         phase      = '0;
         holding    = 1'b0;
         held       = '0;
         head       = 0;
         tail       = 0;
         count      = 0;
         status_due.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SLOT_PERIOD: period_cfg = csr_wdata[PERIOD_W-1:0];
               CSR_OWN_SLOT:    own_cfg    = csr_wdata[PERIOD_W-1:0];
               CSR_SLOT_US:     slot_cfg   = csr_wdata[SLOT_W-1:0];
               CSR_GUARD_US:    guard_cfg  = csr_wdata[SLOT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predicted = schedule_step(req_data);
            status_due.insert(status_due.size(), predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (status_due.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("response %0d arrived with nothing outstanding", results_seen);
            end else begin
               want = status_due[0];
               status_due.delete(0);
               if (rsp_data !== want) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("response %0d mismatch", results_seen);
                     $display({"  expected tx_valid=%0b tx_handle=%h queue_level=%0d",
                               " dropped=%0b busy_res=%0b bad_config=%0b"},
                              want.tx_valid, want.tx_handle, want.queue_level,
                              want.dropped, want.busy_res, want.bad_config);
                     $display({"  actual   tx_valid=%0b tx_handle=%h queue_level=%0d",
                               " dropped=%0b busy_res=%0b bad_config=%0b"},
                              rsp_data.tx_valid, rsp_data.tx_handle, rsp_data.queue_level,
                              rsp_data.dropped, rsp_data.busy_res, rsp_data.bad_config);
                  end
               end
            end
         end
      end
      pending    <= status_due.size();
      fail_count <= errors;
   end

endmodule

>>> verif/tb.sv
// Testbench top for the TDMA own-slot transmit scheduler: clock, reset,
// request and register-write stimulus, response back-pressure and the verdict.
// Depends on tdma_sched_pkg, tdma_own_slot_tx_scheduler and tdma_sched_checker.
`timescale 1ns / 100ps

module tb;
   import tdma_sched_pkg::*;

   localparam int TOTAL_ITEMS  = 1550;
   localparam int LIMIT_CYCLES = 600000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_SLOT_PERIOD;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int items_sent = 0;
   int stall_left = 0;
   bit req_pauses = 1'b0;
   bit rsp_pauses = 1'b0;
   bit req_took = 1'b0;
   bit rsp_took = 1'b0;

   tdma_own_slot_tx_scheduler u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tdma_sched_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tdma_own_slot_tx_scheduler regression: fail");
         $finish;
      end
   end

   // Record transfers at the edge for the falling-edge drivers
   always @(posedge clock) begin
      req_took <= req_valid && !req_stall;
      rsp_took <= rsp_valid && !rsp_stall;
   end

   // Back-pressure the response side: draw a hold for each result
   always @(negedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_took || !rsp_valid) stall_left = rsp_pauses ? $urandom_range(0, 9) : 0;
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Present one request and hold it until the transfer
   task automatic send_item(logic op, logic [HANDLE_W-1:0] handle);
      int gap;
      gap = req_pauses ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {op, handle};
      @(negedge clock);
      while (!req_took) @(negedge clock);
      items_sent++;
   endtask

   // Drain: stop requests and wait for every outstanding response
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Reprogram all four registers once the block is idle
   task automatic set_config(logic [CSR_DATA_W-1:0] period, logic [CSR_DATA_W-1:0] own,
                             logic [CSR_DATA_W-1:0] slot, logic [CSR_DATA_W-1:0] guard);
      settle();
      csr_write(CSR_SLOT_PERIOD, period);
      csr_write(CSR_OWN_SLOT, own);
      csr_write(CSR_SLOT_US, slot);
      csr_write(CSR_GUARD_US, guard);
   endtask

   // Random mix of ticks and enqueues; ticks carry a random ignored handle
   task automatic run_phase(int count, int enq_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < enq_pct) send_item(OP_ENQUEUE, HANDLE_W'($urandom));
         else send_item(OP_TICK, HANDLE_W'($urandom));
      end
   endtask

   initial begin
      logic [PERIOD_W-1:0] period_v;
      logic [PERIOD_W-1:0] own_v;
      logic [SLOT_W-1:0]   slot_v;
      logic [SLOT_W-1:0]   guard_v;
      int                  enq_pct;

      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset defaults: long slots, so nothing goes out yet
      send_item(OP_ENQUEUE, 16'h0000);
      send_item(OP_ENQUEUE, 16'hFFFF);
      send_item(OP_TICK, 16'hFFFF);

      // Zero-length slots: every tick is a boundary, both held handles go out
      set_config(24'd2, 24'd1, 24'd0, 24'd0);
      repeat (3) send_item(OP_TICK, 16'h0000);

      // Zero period marks the own slot bad: fill the queue past full, never send
      set_config(24'd0, 24'd5, 24'd1, 24'd0);
      for (int i = 0; i < 18; i++) send_item(OP_ENQUEUE, 16'hA5A5 ^ 16'(i * 16'h1111));
      send_item(OP_TICK, 16'h5A5A);

      // Walk the phase up under a wide period, then shrink the period below it
      req_pauses = 1'b1;
      rsp_pauses = 1'b1;
      set_config(24'd65535, 24'd65534, 24'd1, 24'd0);
      run_phase(60, 20);
      set_config(24'd4, 24'd3, 24'hFFFFFF, 24'hFFFFFF);
      run_phase(40, 20);
      // Shrink the slot below the time already spent in it
      set_config(24'd4, 24'd3, 24'd2, 24'd0);
      run_phase(40, 20);
      set_config(24'd65535, 24'd65535, 24'd1, 24'd1);
      run_phase(30, 50);

      // Random settings, weighted toward short rounds so packets flow
      while (items_sent < TOTAL_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       period_v = '0;
            1:       period_v = '1;
            2:       period_v = PERIOD_W'($urandom);
            default: period_v = PERIOD_W'($urandom_range(1, 6));
         endcase
         case ($urandom_range(0, 9))
            0:       own_v = '1;
            1:       own_v = period_v;
            2:       own_v = PERIOD_W'($urandom);
            default: own_v = (period_v == 0) ? '0 : PERIOD_W'($urandom_range(0, period_v - 1));
         endcase
         case ($urandom_range(0, 9))
            0:       slot_v = '0;
            1:       slot_v = '1;
            2:       slot_v = SLOT_W'($urandom);
            default: slot_v = SLOT_W'($urandom_range(1, 3));
         endcase
         case ($urandom_range(0, 9))
            0:       guard_v = '1;
            1:       guard_v = SLOT_W'($urandom);
            default: guard_v = SLOT_W'($urandom_range(0, 2));
         endcase
         case ($urandom_range(0, 2))
            0:       enq_pct = 10;
            1:       enq_pct = 35;
            default: enq_pct = 65;
         endcase
         set_config({8'($urandom), period_v}, {8'($urandom), own_v}, slot_v, guard_v);
         req_pauses = ($urandom_range(0, 3) != 0);
         rsp_pauses = ($urandom_range(0, 3) != 0);
         run_phase($urandom_range(20, 80), enq_pct);
      end

      settle();
      repeat (4) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tdma_own_slot_tx_scheduler regression: pass");
      end else begin
         $display("tdma_own_slot_tx_scheduler regression: fail");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/tdma_sched_pkg.sv
hdl/tdma_own_slot_tx_scheduler.sv
verif/tdma_sched_checker.sv
verif/tb.sv
